FILE: sv/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types, constants and elaboration-time table builders for the
// single-bin DFT accumulator.
// ----------------------------------------------------------------------------
package sbd_pkg;

    // default sizes
    localparam int unsigned SamplesLog2Def = 10;
    localparam int unsigned TableLog2Def   = 10;

    // fixed field widths
    localparam int unsigned SampleW = 16;
    localparam int unsigned PhaseW  = 32;
    localparam int unsigned SumW    = 48;
    localparam int unsigned ProdW   = 32;
    localparam int unsigned CordicN = 24;
    localparam int unsigned CfgIdxW = 2;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegStartPhase = 2'd0;
    localparam logic [CfgIdxW-1:0] RegPhaseStep  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegDcBin      = 2'd2;

    // sums captured at the end of a period
    typedef struct packed {
        logic                   sat;
        logic signed [SumW-1:0] re;
        logic signed [SumW-1:0] im;
    } t_snap;

    // quarter-wave sine entry, Taylor series in Q30 rounded to Q15
    function automatic logic [15:0] sine_entry(input int unsigned idx,
                                               input int unsigned tl2);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        int unsigned k;
        x  = (64'd1686629713 * 64'(idx)) >> tl2;
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        for (k = 1; k <= 10; k++) begin
            t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) s = s - t;
            else s = s + t;
        end
        v = (s + 64'd16384) >> 15;
        if (v > 64'd32767) v = 64'd32767;
        return v[15:0];
    endfunction

    // arctan(2^-i) in 2^-32 turns
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [63:0] rad;
        logic [63:0] term;
        logic [63:0] prod;
        int unsigned k;
        rad = 64'd0;
        if (i == 0) return 32'h2000_0000;
        for (k = 0; 62 >= i * (2 * k + 1); k++) begin
            term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
            if (k[0]) rad = rad - term;
            else rad = rad + term;
        end
        prod = (rad >> 30) * 64'd683565276;
        return prod[63:32];
    endfunction

endpackage

FILE: sv/sbd_front.sv
// ----------------------------------------------------------------------------
// sbd_front
// Sample path: phase accumulator, sine/cosine ROM, two multiplies and the
// saturating 48-bit sums. Pushes the sums at each end of period.
// ----------------------------------------------------------------------------
module sbd_front #(
    parameter int unsigned TABLE_LOG2 = sbd_pkg::TableLog2Def
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_restart,
    input  logic [sbd_pkg::PhaseW-1:0]        i_start,
    input  logic [sbd_pkg::PhaseW-1:0]        i_step,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [sbd_pkg::SampleW-1:0] i_sample,
    input  logic                              i_last,
    output logic                              o_push,
    output sbd_pkg::t_snap                    o_snap,
    input  logic                              i_pop
);
    import sbd_pkg::*;

    localparam int unsigned TabN = 1 << TABLE_LOG2;
    localparam int unsigned AddrW = TABLE_LOG2 + 2;

    // sine ROM
    logic [15:0] w_rom [TabN];
    for (genvar g = 0; g < TabN; g++) begin : g_rom
        assign w_rom[g] = sine_entry(g, TABLE_LOG2);
    end

    logic [PhaseW-1:0] r_phase;
    logic [1:0]        r_credit;
    logic              w_acc;

    assign o_ready = (r_credit != 2'd0);
    assign w_acc   = i_valid && o_ready;

    // ROM address folding
    logic [PhaseW-1:0]     w_ph_cos;
    logic [AddrW-1:0]      w_p_sin;
    logic [AddrW-1:0]      w_p_cos;
    logic [TABLE_LOG2-1:0] w_a_sin;
    logic [TABLE_LOG2-1:0] w_a_cos;
    logic                  w_f_sin;
    logic                  w_f_cos;

    always_comb begin
        w_ph_cos = r_phase + 32'h4000_0000;
        w_p_sin  = r_phase[PhaseW-1 -: AddrW];
        w_p_cos  = w_ph_cos[PhaseW-1 -: AddrW];
        w_a_sin  = w_p_sin[AddrW-2] ? -w_p_sin[TABLE_LOG2-1:0] : w_p_sin[TABLE_LOG2-1:0];
        w_a_cos  = w_p_cos[AddrW-2] ? -w_p_cos[TABLE_LOG2-1:0] : w_p_cos[TABLE_LOG2-1:0];
        w_f_sin  = w_p_sin[AddrW-2] && (w_p_sin[TABLE_LOG2-1:0] == '0);
        w_f_cos  = w_p_cos[AddrW-2] && (w_p_cos[TABLE_LOG2-1:0] == '0);
    end

    // stage 1: table read
    logic               r1_v;
    logic               r1_last;
    logic signed [15:0] r1_sample;
    logic [15:0]        r1_sin;
    logic [15:0]        r1_cos;
    logic               r1_fs;
    logic               r1_fc;
    logic               r1_ns;
    logic               r1_nc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= w_acc;
        end
        r1_last   <= i_last;
        r1_sample <= i_sample;
        r1_sin    <= w_rom[w_a_sin];
        r1_cos    <= w_rom[w_a_cos];
        r1_fs     <= w_f_sin;
        r1_fc     <= w_f_cos;
        r1_ns     <= w_p_sin[AddrW-1];
        r1_nc     <= w_p_cos[AddrW-1];
    end

    // stage 2: multiplies
    logic signed [16:0]      w_sin;
    logic signed [16:0]      w_cos;
    logic                    r2_v;
    logic                    r2_last;
    logic signed [ProdW-1:0] r2_re;
    logic signed [ProdW-1:0] r2_im;

    always_comb begin
        w_sin = r1_fs ? 17'sd32767 : $signed({1'b0, r1_sin});
        w_cos = r1_fc ? 17'sd32767 : $signed({1'b0, r1_cos});
        if (r1_ns) w_sin = -w_sin;
        if (r1_nc) w_cos = -w_cos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_last <= r1_last;
        r2_re   <= ProdW'(r1_sample * w_cos);
        r2_im   <= ProdW'(-(r1_sample * w_sin));
    end

    // stage 3: saturating sums
    logic signed [SumW-1:0] r_re;
    logic signed [SumW-1:0] r_im;
    logic                   r_sat;
    logic signed [SumW:0]   w_re_w;
    logic signed [SumW:0]   w_im_w;
    logic signed [SumW-1:0] n_re;
    logic signed [SumW-1:0] n_im;
    logic                   n_sat;

    localparam logic signed [SumW:0] SumMax = (SumW+1)'((64'd1 << (SumW - 1)) - 64'd1);
    localparam logic signed [SumW:0] SumMin = -SumMax - (SumW+1)'(1);

    always_comb begin
        w_re_w = (SumW+1)'(r_re) + (SumW+1)'(r2_re);
        w_im_w = (SumW+1)'(r_im) + (SumW+1)'(r2_im);
        n_sat  = r_sat;
        n_re   = w_re_w[SumW-1:0];
        n_im   = w_im_w[SumW-1:0];
        if (w_re_w > SumMax) begin
            n_re = SumMax[SumW-1:0]; n_sat = 1'b1;
        end else if (w_re_w < SumMin) begin
            n_re = SumMin[SumW-1:0]; n_sat = 1'b1;
        end
        if (w_im_w > SumMax) begin
            n_im = SumMax[SumW-1:0]; n_sat = 1'b1;
        end else if (w_im_w < SumMin) begin
            n_im = SumMin[SumW-1:0]; n_sat = 1'b1;
        end
    end

    assign o_push     = r2_v && r2_last;
    assign o_snap.sat = n_sat;
    assign o_snap.re  = n_re;
    assign o_snap.im  = n_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_re  <= '0;
            r_im  <= '0;
            r_sat <= 1'b0;
        end else if (r2_v) begin
            r_re  <= r2_last ? '0 : n_re;
            r_im  <= r2_last ? '0 : n_im;
            r_sat <= r2_last ? 1'b0 : n_sat;
        end
    end

    // phase accumulator and queue credits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_credit <= 2'd2;
        end else begin
            if (i_restart) r_phase <= i_start;
            else if (w_acc) r_phase <= i_last ? i_start : r_phase + i_step;
            r_credit <= r_credit - 2'(w_acc && i_last) + 2'(i_pop);
        end
    end

endmodule

FILE: sv/sbd_queue.sv
// ----------------------------------------------------------------------------
// sbd_queue
// Two-entry queue of period sums between the sample path and the
// magnitude/angle unit.
// ----------------------------------------------------------------------------
module sbd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sbd_pkg::t_snap i_data,
    output logic           o_valid,
    output sbd_pkg::t_snap o_data,
    input  logic           i_pop
);
    import sbd_pkg::*;

    t_snap      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: sv/sbd_back.sv
// ----------------------------------------------------------------------------
// sbd_back
// Per-period result: squares, bit-serial integer square root and a
// 24-step CORDIC angle, then scaling into the output register.
// ----------------------------------------------------------------------------
module sbd_back #(
    parameter int unsigned SAMPLES_LOG2 = sbd_pkg::SamplesLog2Def
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_dc_bin,
    input  logic           i_valid,
    input  sbd_pkg::t_snap i_snap,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_magnitude,
    output logic [15:0]    o_angle,
    output logic           o_overflow
);
    import sbd_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StSq1  = 3'd1;
    localparam logic [2:0] StSq2  = 3'd2;
    localparam logic [2:0] StAdd  = 3'd3;
    localparam logic [2:0] StRun  = 3'd4;
    localparam logic [2:0] StFin  = 3'd5;

    localparam int unsigned Sh = SAMPLES_LOG2 - 2;
    localparam int unsigned CW = 36;

    logic [31:0] w_atan [CordicN];
    for (genvar g = 0; g < CordicN; g++) begin : g_atan
        assign w_atan[g] = atan_turn(g);
    end

    logic [2:0]            r_st;
    logic [4:0]            r_cnt;
    logic                  r_sat;
    logic                  r_zero;
    logic [31:0]           r_ar;
    logic [31:0]           r_ai;
    logic [63:0]           r_sq;
    logic [63:0]           r_sq2;
    logic [63:0]           r_v;
    logic [63:0]           r_res;
    logic [63:0]           r_bit;
    logic signed [CW-1:0]  r_x;
    logic signed [CW-1:0]  r_y;
    logic [31:0]           r_ang;

    logic signed [31:0]    w_re;
    logic signed [31:0]    w_im;
    logic signed [CW-1:0]  w_xs;
    logic signed [CW-1:0]  w_ys;
    logic [63:0]           w_rb;
    logic [32:0]           w_mag;
    logic [31:0]           w_ang;
    logic                  w_out_free;

    assign w_re       = i_snap.re[SumW-1:16];
    assign w_im       = i_snap.im[SumW-1:16];
    assign w_xs       = r_x >>> r_cnt;
    assign w_ys       = r_y >>> r_cnt;
    assign w_rb       = r_res + r_bit;
    assign w_out_free = !o_valid || i_ready;
    assign o_pop      = (r_st == StIdle) && i_valid;

    // rounding shift of the root and angle rounding
    always_comb begin
        if (i_dc_bin) w_mag = (33'(r_res) + (33'd1 << Sh)) >> (Sh + 1);
        else w_mag = (33'(r_res) + (33'd1 << (Sh - 1))) >> Sh;
        w_ang = r_ang + 32'h0000_8000;
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= StIdle;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_st)
                StIdle: begin
                    if (i_valid) r_st <= StSq1;
                end
                StSq1: r_st <= StSq2;
                StSq2: r_st <= StAdd;
                StAdd: r_st <= StRun;
                StRun: begin
                    if (r_cnt == 5'd31) r_st <= StFin;
                end
                StFin: begin
                    if (w_out_free) begin
                        o_valid <= 1'b1;
                        r_st    <= StIdle;
                    end
                end
                default: r_st <= StIdle;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            StIdle: begin
                r_sat  <= i_snap.sat;
                r_zero <= (w_re == 32'sd0) && (w_im == 32'sd0);
                r_ar   <= w_re[31] ? 32'(-w_re) : 32'(w_re);
                r_ai   <= w_im[31] ? 32'(-w_im) : 32'(w_im);
                r_cnt  <= 5'd0;
                if (w_re[31]) begin
                    r_x   <= -CW'(w_re);
                    r_y   <= -CW'(w_im);
                    r_ang <= 32'h8000_0000;
                end else begin
                    r_x   <= CW'(w_re);
                    r_y   <= CW'(w_im);
                    r_ang <= 32'h0;
                end
            end
            StSq1: r_sq  <= r_ar * r_ar;
            StSq2: r_sq2 <= r_ai * r_ai;
            StAdd: begin
                r_v   <= r_sq + r_sq2;
                r_res <= 64'd0;
                r_bit <= 64'd1 << 62;
            end
            StRun: begin
                // one root digit per cycle
                if (r_v >= w_rb) begin
                    r_v   <= r_v - w_rb;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                // one CORDIC rotation per cycle for the first steps
                if (r_cnt < 5'(CordicN)) begin
                    if (r_y > 0) begin
                        r_x   <= r_x + w_ys;
                        r_y   <= r_y - w_xs;
                        r_ang <= r_ang + w_atan[r_cnt];
                    end else begin
                        r_x   <= r_x - w_ys;
                        r_y   <= r_y + w_xs;
                        r_ang <= r_ang - w_atan[r_cnt];
                    end
                end
                r_cnt <= r_cnt + 5'd1;
            end
            StFin: begin
                if (w_out_free) begin
                    o_magnitude <= (w_mag > 33'd65535) ? 16'hFFFF : w_mag[15:0];
                    o_angle     <= (i_dc_bin || r_zero) ? 16'd0 : w_ang[31:16];
                    o_overflow  <= r_sat;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: sv/single_bin_dft_accumulator.sv
// ----------------------------------------------------------------------------
// single_bin_dft_accumulator
// One-bin DFT over a sample period: magnitude and phase at a programmed tone.
//
// Channel   Dir  Beat contents
// s_axis    in   tdata[15:0] sample, tlast end of period
// m_axis    out  tdata[15:0] magnitude, tdata[31:16] angle, tuser overflow
// cfg       in   we / index / data: start_phase, phase_step, dc_bin
//
// Samples are taken one per cycle while s_axis tready is high; the sample path
// is three stages deep. Each period result passes through the root/CORDIC unit,
// which produces one root digit per cycle and takes the next period when idle.
// Two finished periods can wait for that unit; s_axis tready drops while both
// slots are claimed. Reset is synchronous and active low and needs no sweep.
// ----------------------------------------------------------------------------
module single_bin_dft_accumulator #(
    parameter int unsigned SAMPLES_LOG2 = sbd_pkg::SamplesLog2Def,
    parameter int unsigned TABLE_LOG2   = sbd_pkg::TableLog2Def
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [15:0]                  i_s_axis_tdata,  // [15:0] sample
    input  logic                         i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [31:0]                  o_m_axis_tdata,  // [15:0] magnitude, [31:16] angle
    output logic                         o_m_axis_tuser,  // [0] overflow
    input  logic                         i_cfg_we,
    input  logic [sbd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [31:0]                  i_cfg_data
);
    import sbd_pkg::*;

    logic [PhaseW-1:0] r_start_phase;
    logic [PhaseW-1:0] r_phase_step;
    logic              r_dc_bin;
    logic              w_restart;
    logic [PhaseW-1:0] w_start;

    // configuration registers
    always_comb begin
        w_restart = 1'b0;
        w_start   = r_start_phase;
        unique case (i_cfg_index)
            RegStartPhase: begin
                w_restart = i_cfg_we;
                w_start   = i_cfg_data;
            end
            RegPhaseStep, RegDcBin: w_restart = i_cfg_we;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_phase <= '0;
            r_phase_step  <= '0;
            r_dc_bin      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegStartPhase: r_start_phase <= i_cfg_data;
                RegPhaseStep:  r_phase_step  <= i_cfg_data;
                RegDcBin:      r_dc_bin      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic  w_push;
    logic  w_pop;
    logic  w_q_valid;
    t_snap w_snap_in;
    t_snap w_snap_out;
    logic [15:0] w_mag;
    logic [15:0] w_ang;

    sbd_front #(
        .TABLE_LOG2(TABLE_LOG2)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_start   (w_start),
        .i_step    (r_phase_step),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_sample  (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .o_push    (w_push),
        .o_snap    (w_snap_in),
        .i_pop     (w_pop)
    );

    sbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_snap_in),
        .o_valid (w_q_valid),
        .o_data  (w_snap_out),
        .i_pop   (w_pop)
    );

    sbd_back #(
        .SAMPLES_LOG2(SAMPLES_LOG2)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dc_bin    (r_dc_bin),
        .i_valid     (w_q_valid),
        .i_snap      (w_snap_out),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_magnitude (w_mag),
        .o_angle     (w_ang),
        .o_overflow  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {w_ang, w_mag};

endmodule

FILE: dv/sbd_checker.sv
// ----------------------------------------------------------------------------
// sbd_checker
// Watches the sample, result and register channels of the single-bin DFT
// accumulator, computes each period's magnitude, angle and overflow, and
// compares every result transfer against the oldest pending prediction.
// ----------------------------------------------------------------------------
module sbd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import sbd_pkg::*;

    localparam int unsigned SL2 = SamplesLog2Def;
    localparam int unsigned TL2 = TableLog2Def;
    localparam int unsigned TabN = 1 << TL2;
    localparam longint SumMax = 64'sd140737488355327;
    localparam longint SumMin = -64'sd140737488355327 - 1;

    typedef struct packed {
        logic [15:0] mag;
        logic [15:0] ang;
        logic        ovf;
    } t_period_res;

    logic [15:0] qsine [TabN];
    logic [31:0] atan_lut [CordicN];

    // register copy and period state
    logic [31:0] start_ph;
    logic [31:0] step_ph;
    logic        dc_sel;
    logic [31:0] ph_acc;
    longint      re_acc;
    longint      im_acc;
    logic        sat_seen;

    t_period_res period_q[$];
    int          mism;

    assign o_errors  = mism;
    assign o_pending = period_q.size();

    // table values built independently of the package helpers
    initial begin
        longint unsigned x, x2, t, s, v, rad, term;
        for (int i = 0; i < TabN; i++) begin
            x  = (64'd1686629713 * longint'(i)) >> TL2;
            x2 = (x * x) >> 30;
            t  = x;
            s  = x;
            for (int k = 1; k <= 10; k++) begin
                t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2) s -= t;
                else s += t;
            end
            v = (s + 64'd16384) >> 15;
            qsine[i] = (v > 32767) ? 16'd32767 : v[15:0];
        end
        atan_lut[0] = 32'h2000_0000;
        for (int i = 1; i < CordicN; i++) begin
            rad = 0;
            for (int k = 0; 62 >= i * (2 * k + 1); k++) begin
                term = (64'd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
                if (k % 2) rad -= term;
                else rad += term;
            end
            v = (rad >> 30) * 64'd683565276;
            atan_lut[i] = v[63:32];
        end
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sine_at(logic [31:0] ph);
        logic [31:0] p;
        int unsigned q, r, k;
        longint val;
        p = ph >> (32 - (TL2 + 2));
        q = (p >> TL2) & 3;
        r = p & (TabN - 1);
        k = (q & 1) ? TabN - r : r;
        val = (k >= TabN) ? 32767 : longint'(qsine[k]);
        return (q & 2) ? -val : val;
    endfunction

    function automatic longint clamp_sum(longint acc, longint d, ref logic sat);
        longint s;
        s = acc + d;
        if (s > SumMax) begin
            sat = 1'b1;
            return SumMax;
        end
        if (s < SumMin) begin
            sat = 1'b1;
            return SumMin;
        end
        return s;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] vector_angle(longint x, longint y);
        logic [31:0] a;
        longint xs, ys;
        a = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            a = 32'h8000_0000;
        end
        for (int i = 0; i < CordicN; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y > 0) begin
                x += ys;
                y -= xs;
                a += atan_lut[i];
            end else begin
                x -= ys;
                y += xs;
                a -= atan_lut[i];
            end
        end
        return a;
    endfunction

    // closes a period: magnitude, angle and overflow from the sums
    function automatic t_period_res finish_period();
        t_period_res r;
        longint re, im;
        longint unsigned ar, ai, h, m;
        int sh;
        logic [31:0] a;
        re = fshift(re_acc, 16);
        im = fshift(im_acc, 16);
        ar = (re < 0) ? -re : re;
        ai = (im < 0) ? -im : im;
        h  = root_floor(ar * ar + ai * ai);
        sh = SL2 - 1 - (dc_sel ? 0 : 1);
        m  = (sh > 0) ? (h + (64'd1 << (sh - 1))) >> sh : h;
        r.mag = (m > 65535) ? 16'hFFFF : m[15:0];
        r.ang = '0;
        if (!dc_sel && (re != 0 || im != 0)) begin
            a = vector_angle(re, im) + 32'h8000;
            r.ang = a[31:16];
        end
        r.ovf = sat_seen;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_period_res exp_r, got;
        longint smp;
        if (!i_rst_n) begin
            start_ph = 0;
            step_ph  = 0;
            dc_sel   = 1'b1;
            ph_acc   = 0;
            re_acc   = 0;
            im_acc   = 0;
            sat_seen = 1'b0;
            mism     = 0;
            period_q.delete();
        end else begin
            // register write restarts the period
            if (i_cfg_we && i_cfg_index inside {RegStartPhase, RegPhaseStep, RegDcBin}) begin
                case (i_cfg_index)
                    RegStartPhase: start_ph = i_cfg_data;
                    RegPhaseStep:  step_ph  = i_cfg_data;
                    default:       dc_sel   = i_cfg_data[0];
                endcase
                ph_acc = start_ph;
                re_acc = 0;
                im_acc = 0;
                sat_seen = 1'b0;
            end
            // sample transfer
            if (i_s_tvalid && i_s_tready) begin
                smp = longint'($signed(i_s_tdata));
                re_acc = clamp_sum(re_acc, smp * sine_at(ph_acc + 32'h4000_0000), sat_seen);
                im_acc = clamp_sum(im_acc, -(smp * sine_at(ph_acc)), sat_seen);
                ph_acc += step_ph;
                if (i_s_tlast) begin
                    period_q.push_back(finish_period());
                    ph_acc = start_ph;
                    re_acc = 0;
                    im_acc = 0;
                    sat_seen = 1'b0;
                end
            end
            // result transfer
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[15:0], i_m_tdata[31:16], i_m_tuser};
                if (period_q.size() == 0) begin
                    mism++;
                    if (mism <= 10)
                        $display("unexpected result mag=%0d ang=%0d ovf=%0b",
                                 got.mag, $signed(got.ang), got.ovf);
                end else begin
                    exp_r = period_q.pop_front();
                    if (got !== exp_r) begin
                        mism++;
                        if (mism <= 10)
                            $display("mismatch: exp mag=%0d ang=%0d ovf=%0b, got mag=%0d ang=%0d ovf=%0b",
                                     exp_r.mag, $signed(exp_r.ang), exp_r.ovf,
                                     got.mag, $signed(got.ang), got.ovf);
                    end
                end
            end
        end
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the single-bin DFT accumulator: directed periods at the field
// and register extremes, then random periods under several register settings
// with random idling on both streams; the checker gives the verdict count.
// ----------------------------------------------------------------------------
module tb_top;
    import sbd_pkg::*;

    localparam int Limit = 400000;
    localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          idle_pct = 30;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    single_bin_dft_accumulator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tlast(s_tlast),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    sbd_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // result-side stalls
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > Limit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one sample transfer, with a random gap first; tvalid stays up afterwards
    task automatic send_sample(input logic [15:0] smp, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every predicted result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // random period of small length, mostly with a random-content waveform
    task automatic random_period(input int len);
        logic [15:0] smp;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(3))
                0: smp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                default: smp = 16'($urandom);
            endcase
            send_sample(smp, i == len - 1);
        end
    endtask

    initial begin
        int sent;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: DC bin with extremes
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0000, 1'b1);              // zero vector
        send_sample(16'h7FFF, 1'b1);
        write_reg(RegPhaseStep, 32'h0040_0000);
        write_reg(RegDcBin, 32'hFFFF_FFFE);       // tone bin
        write_reg(RegStartPhase, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++) send_sample(16'h8000, i == 7);
        send_sample(16'h0000, 1'b1);
        write_reg(RegUnused, 32'hDEAD_BEEF);      // unknown index, restarts nothing
        // long full-scale run without a last mark
        write_reg(RegPhaseStep, 32'h0000_0000);
        write_reg(RegStartPhase, 32'h0000_0000);
        idle_pct = 0;
        for (int i = 0; i < 300; i++) send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        idle_pct = 30;
        // register write mid-period restarts accumulation
        send_sample(16'h1234, 1'b0);
        write_reg(RegPhaseStep, 32'hFFFF_FFFF);
        send_sample(16'h4321, 1'b1);

        // random phases with several settings
        sent = 0;
        for (int ph = 0; sent < 1000; ph++) begin
            if (ph % 4 == 0) begin
                write_reg(RegStartPhase, (ph % 8 == 0) ? 32'h0 : $urandom);
                write_reg(RegPhaseStep, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom);
                write_reg(RegDcBin, $urandom);
                idle_pct = (ph % 12 == 4) ? 0 : 30;
            end
            begin
                int len;
                len = $urandom_range(1, 40);
                random_period(len);
                sent += len;
            end
        end
        drain();
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/sbd_pkg.sv
sv/sbd_front.sv
sv/sbd_queue.sv
sv/sbd_back.sv
sv/single_bin_dft_accumulator.sv
dv/sbd_checker.sv
dv/tb_top.sv
